/* hw/rtl/quintic_trajectory_point_assert.svh */
// assertion macros used by quintic_trajectory_point.sv
`ifndef QUINTIC_TRAJECTORY_POINT_ASSERT_SVH
`define QUINTIC_TRAJECTORY_POINT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define QTP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qtp implication check failed");

// next-cycle implication, checked out of reset
`define QTP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qtp next-cycle check failed");

`endif

/* hw/rtl/qtp_pkg.sv */
`timescale 1ns / 1ps

package qtp_pkg;

  // fixed point format of positions and times
  localparam int FRAC_BITS = 16;

  // 1.0 in the Q1.30 profile domain
  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic [34:0] TEN30 = 35'd10 << 30;

  // shifts that bring the rates back to FRAC_BITS
  localparam int VSH   = 30 - FRAC_BITS;
  localparam int ASH   = 2 * FRAC_BITS - 30;
  localparam int ASH_L = (ASH > 0) ? ASH : 0;
  localparam int ASH_R = (ASH < 0) ? -ASH : 0;

  // datapath widths
  localparam int DUR_W = 31;
  localparam int AD_W  = 33;
  localparam int G_W   = 36;
  localparam int VN_W  = AD_W + G_W;
  localparam int AN_W  = VN_W + ASH_L;
  localparam int VT_W  = VN_W - 32;
  localparam int AT_W  = AN_W - 32;
  localparam int VD_W  = DUR_W + VSH;
  localparam int TT_W  = 2 * DUR_W;
  localparam int CV_W  = (VT_W > VD_W) ? VT_W : VD_W;
  localparam int CA_W  = (AT_W > TT_W) ? AT_W : TT_W;

  // pipeline depth
  localparam int SDIV_N = 31;
  localparam int RDIV_N = 32;
  localparam int LAT    = 1 + SDIV_N + 5 + RDIV_N + 1;

  localparam logic [30:0] DUR_RESET = 31'd65536;

  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_MOTION = 2'd1,
    PH_AFTER  = 2'd2
  } phase_t;

  // side data that travels with each word
  typedef struct packed {
    phase_t             phase;
    logic signed [31:0] base;
    logic signed [32:0] delta;
    logic               kneg;
    logic signed [31:0] pos;
    logic               psat;
  } ctl_t;

endpackage

/* hw/rtl/quintic_trajectory_point.sv */
`timescale 1ns / 1ps
// channel | ports                                          | handshake
// input   | in_sample_time, in_start_position, in_end_pos.. | start & !busy
// result  | out_position .. out_saturated                  | out_valid strobe, 1 cycle
// config  | cfg_total_duration                             | cfg_valid & cfg_ready
//
// one word per cycle in; each word passes the input register, the 31-step divider
// for t/T, the m1 to m5 stages, the 32-step divider stages for the rate magnitudes
// and the output register, one quotient bit per divider stage
// synchronous active-low reset clears valid bits and sets T to 1.0
// busy is never raised and cfg_ready is always high; the result cannot be held off

`include "quintic_trajectory_point_assert.svh"

module quintic_trajectory_point (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_sample_time,
  input  logic [31:0] in_start_position,
  input  logic [31:0] in_end_position,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_total_duration,
  output logic        out_valid,
  output logic [31:0] out_position,
  output logic [31:0] out_velocity,
  output logic [31:0] out_acceleration,
  output logic [1:0]  out_phase,
  output logic        out_saturated
);

  localparam int SN = qtp_pkg::SDIV_N;
  localparam int RN = qtp_pkg::RDIV_N;

  // duration register
  logic [30:0] cfg_dur_r;
  logic [30:0] dur;
  logic [qtp_pkg::TT_W-1:0] dur_sq_r;
  logic [qtp_pkg::VD_W-1:0] vdiv;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dur_r <= qtp_pkg::DUR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_dur_r <= cfg_total_duration;
    end
  end

  assign dur  = (cfg_dur_r == 31'd0) ? 31'd1 : cfg_dur_r;
  assign vdiv = qtp_pkg::VD_W'(dur) << qtp_pkg::VSH;

  always_ff @(posedge clk) begin
    dur_sq_r <= qtp_pkg::TT_W'(dur) * qtp_pkg::TT_W'(dur);
  end

  // input stage: phase, base position, distance
  logic             in_v_r;
  qtp_pkg::ctl_t    in_ctl_r;
  logic [30:0]      in_t_r;
  qtp_pkg::ctl_t    in_ctl;

  always_comb begin
    in_ctl       = '0;
    in_ctl.delta = $signed({in_end_position[31], in_end_position})
                 - $signed({in_start_position[31], in_start_position});
    in_ctl.base  = $signed(in_start_position);
    if (in_sample_time[31]) begin
      in_ctl.phase = qtp_pkg::PH_BEFORE;
    end else if (in_sample_time[30:0] > dur) begin
      in_ctl.phase = qtp_pkg::PH_AFTER;
      in_ctl.base  = $signed(in_end_position);
    end else begin
      in_ctl.phase = qtp_pkg::PH_MOTION;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_ctl_r <= in_ctl;
    in_t_r   <= in_sample_time[30:0];
  end

  // s = t * 2^30 / T, one quotient bit per stage
  logic                sdv_r  [SN];
  qtp_pkg::ctl_t       sctl_r [SN];
  logic [30:0]         srem_r [SN];
  logic [30:0]         squo_r [SN];

  for (genvar j = 0; j < SN; j++) begin : g_sdiv
    logic [31:0]   r_sh;
    logic [30:0]   q_in;
    logic          v_in;
    qtp_pkg::ctl_t c_in;
    logic          take;

    if (j == 0) begin : g_head
      assign r_sh = {1'b0, in_t_r};
      assign q_in = '0;
      assign v_in = in_v_r;
      assign c_in = in_ctl_r;
    end else begin : g_body
      assign r_sh = {srem_r[j-1], 1'b0};
      assign q_in = squo_r[j-1];
      assign v_in = sdv_r[j-1];
      assign c_in = sctl_r[j-1];
    end

    assign take = r_sh >= {1'b0, dur};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sdv_r[j] <= 1'b0;
      end else begin
        sdv_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      sctl_r[j] <= c_in;
      srem_r[j] <= take ? 31'(r_sh - {1'b0, dur}) : 31'(r_sh);
      squo_r[j] <= take ? (q_in | (31'd1 << (SN - 1 - j))) : q_in;
    end
  end

  // m1: s^2 and s(1-s)
  logic [30:0]   s_a;
  logic [61:0]   m1_sq;
  logic [61:0]   m1_sm;
  logic          m1_v_r;
  qtp_pkg::ctl_t m1_ctl_r;
  logic [30:0]   m1_s_r;
  logic [30:0]   m1_s2_r;
  logic [30:0]   m1_q_r;

  assign s_a   = squo_r[SN-1];
  assign m1_sq = 62'(s_a) * 62'(s_a);
  assign m1_sm = 62'(s_a) * 62'(qtp_pkg::ONE30 - s_a);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else begin
      m1_v_r <= sdv_r[SN-1];
    end
  end

  always_ff @(posedge clk) begin
    m1_ctl_r <= sctl_r[SN-1];
    m1_s_r   <= s_a;
    m1_s2_r  <= m1_sq[60:30];
    m1_q_r   <= m1_sm[60:30];
  end

  // m2: s^3, polynomial inner term, q^2 and q|1-2s|
  logic [61:0]   m2_s3p;
  logic [61:0]   m2_qqp;
  logic [61:0]   m2_qap;
  logic [31:0]   two_s;
  logic          kneg;
  logic [31:0]   alin;
  logic [34:0]   inner;
  qtp_pkg::ctl_t m2_ctl;
  logic          m2_v_r;
  qtp_pkg::ctl_t m2_ctl_r;
  logic [30:0]   m2_s3_r;
  logic [34:0]   m2_inner_r;
  logic [30:0]   m2_qq_r;
  logic [30:0]   m2_qa_r;

  assign two_s  = {m1_s_r, 1'b0};
  assign kneg   = two_s > {1'b0, qtp_pkg::ONE30};
  assign alin   = kneg ? (two_s - {1'b0, qtp_pkg::ONE30})
                       : ({1'b0, qtp_pkg::ONE30} - two_s);
  assign m2_s3p = 62'(m1_s2_r) * 62'(m1_s_r);
  assign m2_qqp = 62'(m1_q_r) * 62'(m1_q_r);
  assign m2_qap = 62'(m1_q_r) * 62'(alin);
  assign inner  = qtp_pkg::TEN30 - 35'(m1_s_r) * 35'd15 + 35'(m1_s2_r) * 35'd6;

  // side data with the sign of 1-2s
  always_comb begin
    m2_ctl      = m1_ctl_r;
    m2_ctl.kneg = kneg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    m2_ctl_r   <= m2_ctl;
    m2_s3_r    <= m2_s3p[60:30];
    m2_inner_r <= inner;
    m2_qq_r    <= m2_qqp[60:30];
    m2_qa_r    <= m2_qap[60:30];
  end

  // m3: h, g = 30 q^2, |k| = 60 q|1-2s|
  logic [65:0]            m3_hp;
  logic [35:0]            m3_hs;
  logic                   m3_v_r;
  qtp_pkg::ctl_t          m3_ctl_r;
  logic [30:0]            m3_h_r;
  logic [qtp_pkg::G_W-1:0] m3_g_r;
  logic [qtp_pkg::G_W-1:0] m3_ak_r;

  assign m3_hp = 66'(m2_s3_r) * 66'(m2_inner_r);
  assign m3_hs = m3_hp[65:30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else begin
      m3_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    m3_ctl_r <= m2_ctl_r;
    m3_h_r   <= (m3_hs > 36'(qtp_pkg::ONE30)) ? qtp_pkg::ONE30 : m3_hs[30:0];
    m3_g_r   <= qtp_pkg::G_W'(m2_qq_r) * qtp_pkg::G_W'(30);
    m3_ak_r  <= qtp_pkg::G_W'(m2_qa_r) * qtp_pkg::G_W'(60);
  end

  // m4: products with the distance
  logic [qtp_pkg::AD_W-1:0] ad;
  logic                     m4_v_r;
  qtp_pkg::ctl_t            m4_ctl_r;
  logic signed [64:0]       m4_dh_r;
  logic [qtp_pkg::VN_W-1:0] m4_vn_r;
  logic [qtp_pkg::VN_W-1:0] m4_ap_r;

  assign ad = m3_ctl_r.delta[32] ? qtp_pkg::AD_W'(-m3_ctl_r.delta)
                                 : qtp_pkg::AD_W'(m3_ctl_r.delta);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_v_r <= 1'b0;
    end else begin
      m4_v_r <= m3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    m4_ctl_r <= m3_ctl_r;
    m4_dh_r  <= $signed(m3_ctl_r.delta) * $signed({1'b0, m3_h_r});
    m4_vn_r  <= qtp_pkg::VN_W'(ad) * qtp_pkg::VN_W'(m3_g_r);
    m4_ap_r  <= qtp_pkg::VN_W'(ad) * qtp_pkg::VN_W'(m3_ak_r);
  end

  // m5: position with clip, divider setup and quotient overflow checks
  logic signed [35:0]       pos_w;
  logic [qtp_pkg::AN_W-1:0] anum;
  logic [qtp_pkg::VT_W-1:0] vtop;
  logic [qtp_pkg::AT_W-1:0] atop;
  qtp_pkg::ctl_t            m5_ctl;
  logic                     m5_v_r;
  qtp_pkg::ctl_t            m5_ctl_r;
  logic [qtp_pkg::VD_W-1:0] m5_vrem_r;
  logic [31:0]              m5_vlow_r;
  logic                     m5_vovr_r;
  logic [qtp_pkg::TT_W-1:0] m5_arem_r;
  logic [31:0]              m5_alow_r;
  logic                     m5_aovr_r;

  assign pos_w = 36'($signed(m4_ctl_r.base)) + 36'(m4_dh_r >>> 30);
  assign anum  = (qtp_pkg::AN_W'(m4_ap_r) << qtp_pkg::ASH_L) >> qtp_pkg::ASH_R;
  assign vtop  = m4_vn_r[qtp_pkg::VN_W-1:32];
  assign atop  = anum[qtp_pkg::AN_W-1:32];

  always_comb begin
    m5_ctl = m4_ctl_r;
    m5_ctl.psat = 1'b0;
    if (pos_w > 36'sh0_7FFF_FFFF) begin
      m5_ctl.pos  = 32'sh7FFF_FFFF;
      m5_ctl.psat = 1'b1;
    end else if (pos_w < -36'sh0_8000_0000) begin
      m5_ctl.pos  = 32'sh8000_0000;
      m5_ctl.psat = 1'b1;
    end else begin
      m5_ctl.pos  = pos_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m5_v_r <= 1'b0;
    end else begin
      m5_v_r <= m4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    m5_ctl_r  <= m5_ctl;
    m5_vrem_r <= qtp_pkg::VD_W'(vtop);
    m5_vlow_r <= m4_vn_r[31:0];
    m5_vovr_r <= qtp_pkg::CV_W'(vtop) >= qtp_pkg::CV_W'(vdiv);
    m5_arem_r <= qtp_pkg::TT_W'(atop);
    m5_alow_r <= anum[31:0];
    m5_aovr_r <= qtp_pkg::CA_W'(atop) >= qtp_pkg::CA_W'(dur_sq_r);
  end

  // rate magnitudes, one quotient bit per stage for both dividers
  logic                     dv_r   [RN];
  qtp_pkg::ctl_t            dctl_r [RN];
  logic [qtp_pkg::VD_W-1:0] vrem_r [RN];
  logic [31:0]              vlow_r [RN];
  logic [31:0]              vquo_r [RN];
  logic                     vovr_r [RN];
  logic [qtp_pkg::TT_W-1:0] arem_r [RN];
  logic [31:0]              alow_r [RN];
  logic [31:0]              aquo_r [RN];
  logic                     aovr_r [RN];

  for (genvar k = 0; k < RN; k++) begin : g_rdiv
    logic                     v_in;
    qtp_pkg::ctl_t            c_in;
    logic [qtp_pkg::VD_W-1:0] vr_in;
    logic [31:0]              vl_in;
    logic [31:0]              vq_in;
    logic                     vo_in;
    logic [qtp_pkg::TT_W-1:0] ar_in;
    logic [31:0]              al_in;
    logic [31:0]              aq_in;
    logic                     ao_in;
    logic [qtp_pkg::VD_W:0]   vr_sh;
    logic [qtp_pkg::TT_W:0]   ar_sh;
    logic                     vtake;
    logic                     atake;

    if (k == 0) begin : g_head
      assign v_in  = m5_v_r;
      assign c_in  = m5_ctl_r;
      assign vr_in = m5_vrem_r;
      assign vl_in = m5_vlow_r;
      assign vq_in = '0;
      assign vo_in = m5_vovr_r;
      assign ar_in = m5_arem_r;
      assign al_in = m5_alow_r;
      assign aq_in = '0;
      assign ao_in = m5_aovr_r;
    end else begin : g_body
      assign v_in  = dv_r[k-1];
      assign c_in  = dctl_r[k-1];
      assign vr_in = vrem_r[k-1];
      assign vl_in = vlow_r[k-1];
      assign vq_in = vquo_r[k-1];
      assign vo_in = vovr_r[k-1];
      assign ar_in = arem_r[k-1];
      assign al_in = alow_r[k-1];
      assign aq_in = aquo_r[k-1];
      assign ao_in = aovr_r[k-1];
    end

    assign vr_sh = {vr_in, vl_in[31]};
    assign ar_sh = {ar_in, al_in[31]};
    assign vtake = vr_sh >= {1'b0, vdiv};
    assign atake = ar_sh >= {1'b0, dur_sq_r};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else begin
        dv_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      dctl_r[k] <= c_in;
      vrem_r[k] <= vtake ? qtp_pkg::VD_W'(vr_sh - {1'b0, vdiv}) : qtp_pkg::VD_W'(vr_sh);
      vlow_r[k] <= {vl_in[30:0], 1'b0};
      vquo_r[k] <= {vq_in[30:0], vtake};
      vovr_r[k] <= vo_in;
      arem_r[k] <= atake ? qtp_pkg::TT_W'(ar_sh - {1'b0, dur_sq_r})
                         : qtp_pkg::TT_W'(ar_sh);
      alow_r[k] <= {al_in[30:0], 1'b0};
      aquo_r[k] <= {aq_in[30:0], atake};
      aovr_r[k] <= ao_in;
    end
  end

  // output stage: sign, clip, phase override
  qtp_pkg::ctl_t fc;
  logic          dneg;
  logic          vneg;
  logic          aneg;
  logic [31:0]   vmag;
  logic [31:0]   amag;
  logic [31:0]   vlim;
  logic [31:0]   alim;
  logic          vclip;
  logic          aclip;
  logic [31:0]   vmag_c;
  logic [31:0]   amag_c;
  logic          out_valid_r;
  logic [31:0]   out_pos_r;
  logic [31:0]   out_vel_r;
  logic [31:0]   out_acc_r;
  logic [1:0]    out_phase_r;
  logic          out_sat_r;

  assign fc     = dctl_r[RN-1];
  assign dneg   = fc.delta[32];
  assign vmag   = vquo_r[RN-1];
  assign amag   = aquo_r[RN-1];
  assign vneg   = dneg && (vovr_r[RN-1] || (vmag != 32'd0));
  assign aneg   = (dneg != fc.kneg) && (aovr_r[RN-1] || (amag != 32'd0));
  assign vlim   = vneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign alim   = aneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign vclip  = vovr_r[RN-1] || (vmag > vlim);
  assign aclip  = aovr_r[RN-1] || (amag > alim);
  assign vmag_c = vclip ? vlim : vmag;
  assign amag_c = aclip ? alim : amag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_r[RN-1];
    end
  end

  always_ff @(posedge clk) begin
    out_phase_r <= fc.phase;
    if (fc.phase == qtp_pkg::PH_MOTION) begin
      out_pos_r <= fc.pos;
      out_vel_r <= vneg ? (32'd0 - vmag_c) : vmag_c;
      out_acc_r <= aneg ? (32'd0 - amag_c) : amag_c;
      out_sat_r <= fc.psat || vclip || aclip;
    end else begin
      out_pos_r <= fc.base;
      out_vel_r <= 32'd0;
      out_acc_r <= 32'd0;
      out_sat_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_pos_r;
  assign out_velocity     = out_vel_r;
  assign out_acceleration = out_acc_r;
  assign out_phase        = out_phase_r;
  assign out_saturated    = out_sat_r;

  // checks
  `QTP_ASSERT_IMP(a_fixed_latency, start && !busy, ##(qtp_pkg::LAT) out_valid)
  `QTP_ASSERT_IMP(a_rest_zero, out_valid && (out_phase != qtp_pkg::PH_MOTION), (out_velocity == 32'd0) && (out_acceleration == 32'd0) && !out_saturated)
  `QTP_ASSERT_NXT(a_dur_hold, !(cfg_valid && cfg_ready), $stable(cfg_dur_r))

endmodule
